### rtl/lra_pkg.sv
// ----------------------------------------------------------------------------
// lra_pkg: shared types and constants of the liveness register allocator
// Sizes of the register file, the request and result beats, the store control
// bundle and the sequencer states.
// ----------------------------------------------------------------------------
package lra_pkg;

	localparam int NUM_REGS   = 64;
	localparam int INDEX_BITS = 16;
	localparam int COMPS      = 4;
	localparam int REG_BITS   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int LEN_W      = $clog2(NUM_REGS + 1);
	localparam int NEED_W     = $clog2(COMPS + 1);

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_SINGLE = 2'd1,
		REQ_RANGE  = 2'd2,
		REQ_NOP    = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STAMP
	} state_t;

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [COMPS-1:0][INDEX_BITS-1:0] row_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] first_def;
		logic [15:0] last_use;
		logic [6:0]  count;
	} req_t;

	typedef struct packed {
		logic [5:0] reg_id;
		logic [3:0] write_mask;
		logic       status;
	} res_t;

	typedef struct packed {
		logic                clear;
		logic                rd_en;
		logic [REG_BITS-1:0] rd_addr;
		logic                wr_en;
		logic [REG_BITS-1:0] wr_addr;
		row_t                wr_data;
	} store_ctl_t;

	typedef struct packed {
		logic [COMPS-1:0] mask;
		logic             ok;
		logic             all_free;
	} fit_t;

endpackage

### rtl/liveness_register_allocator.sv
// ----------------------------------------------------------------------------
// liveness_register_allocator: first-fit register allocator
// A request beat is taken when start is high and busy is low. Each request
// gives exactly one result beat, shown on result for one cycle with done
// high; the receiver cannot hold it off.
// A clear, an unknown request or a request with a bad count answers in the
// cycle after it is taken. Other requests scan the register file one
// register per cycle through the single store read port and the fit check.
// A single-register request answers once it finds the first register that
// fits, or after the last register misses. A range request scans up to the
// end of the first run of count free registers, then writes those registers
// one per cycle and answers in the cycle after the last write. Busy stays
// high while a request scans or writes the store, so at most one such
// request is in flight.
// Reset and a clear request both empty the store at once by dropping the
// row valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module liveness_register_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lra_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output lra_pkg::res_t result
);

	lra_pkg::state_t state_q, state_nx;
	lra_pkg::req_t req_q;
	logic [lra_pkg::LEN_W-1:0] rd_q, run_start_q, run_len_q, cnt_q, left_q;
	logic [lra_pkg::REG_BITS-1:0] ev_q, wr_q;
	logic ev_vld_q;
	logic done_q;
	lra_pkg::res_t res_q, res_nx;

	lra_pkg::store_ctl_t ctl;
	lra_pkg::row_t rd_data;
	lra_pkg::fit_t fit;
	lra_pkg::index_t fw_idx, lr_idx;

	logic accept, is_single, is_range, ok_single, ok_range, go_scan, imm_done;
	logic single_q, eval, last_row, hit_single, hit_range, miss, stamp_last;
	logic [lra_pkg::LEN_W-1:0] run_len_nx;

	lra_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_data (rd_data)
	);

	lra_fit u_fit (
		.row       (rd_data),
		.first_def (fw_idx),
		.need      (lra_pkg::NEED_W'(req_q.count)),
		.fit       (fit)
	);

	assign fw_idx = lra_pkg::INDEX_BITS'(req_q.first_def);
	assign lr_idx = lra_pkg::INDEX_BITS'(req_q.last_use);

	always_comb begin
		accept     = start && (state_q == lra_pkg::ST_IDLE);
		is_single  = (req.req_type == lra_pkg::REQ_SINGLE);
		is_range   = (req.req_type == lra_pkg::REQ_RANGE);
		ok_single  = (req.count != '0) && ({25'd0, req.count} <= 32'(lra_pkg::COMPS));
		ok_range   = (req.count != '0) && ({25'd0, req.count} <= 32'(lra_pkg::NUM_REGS));
		go_scan    = accept && ((is_single && ok_single) || (is_range && ok_range));
		imm_done   = accept && !go_scan;
		single_q   = (req_q.req_type == lra_pkg::REQ_SINGLE);
		eval       = (state_q == lra_pkg::ST_SCAN) && ev_vld_q;
		last_row   = (ev_q == lra_pkg::REG_BITS'(lra_pkg::NUM_REGS - 1));
		run_len_nx = run_len_q + 1'b1;
		hit_single = eval && single_q && fit.ok;
		hit_range  = eval && !single_q && fit.all_free && (run_len_nx == cnt_q);
		miss       = eval && last_row && !hit_single && !hit_range;
		stamp_last = (state_q == lra_pkg::ST_STAMP) && (left_q == lra_pkg::LEN_W'(1));
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			lra_pkg::ST_IDLE: begin
				if (go_scan) begin
					state_nx = lra_pkg::ST_SCAN;
				end
			end
			lra_pkg::ST_SCAN: begin
				if (hit_range) begin
					state_nx = lra_pkg::ST_STAMP;
				end else if (hit_single || miss) begin
					state_nx = lra_pkg::ST_IDLE;
				end
			end
			lra_pkg::ST_STAMP: begin
				if (stamp_last) begin
					state_nx = lra_pkg::ST_IDLE;
				end
			end
			default: state_nx = lra_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.clear   = accept && (req.req_type == lra_pkg::REQ_CLEAR);
		ctl.rd_en   = (state_q == lra_pkg::ST_SCAN) &&
			(rd_q < lra_pkg::LEN_W'(lra_pkg::NUM_REGS));
		ctl.rd_addr = rd_q[lra_pkg::REG_BITS-1:0];
		ctl.wr_en   = hit_single || (state_q == lra_pkg::ST_STAMP);
		ctl.wr_addr = (state_q == lra_pkg::ST_STAMP) ? wr_q : ev_q;
		for (int c = 0; c < lra_pkg::COMPS; c++) begin
			if ((state_q == lra_pkg::ST_STAMP) || fit.mask[c]) begin
				ctl.wr_data[c] = lr_idx;
			end else begin
				ctl.wr_data[c] = rd_data[c];
			end
		end

		res_nx = '0;
		if (imm_done) begin
			res_nx.status = (is_single || is_range) ? lra_pkg::STATUS_FULL
				: lra_pkg::STATUS_OK;
		end else if (hit_single) begin
			res_nx.reg_id     = 6'(ev_q);
			res_nx.write_mask = fit.mask;
		end else if (stamp_last) begin
			res_nx.reg_id     = 6'(run_start_q);
			res_nx.write_mask = '1;
		end else if (miss) begin
			res_nx.status = lra_pkg::STATUS_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lra_pkg::ST_IDLE;
			ev_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_nx;
			ev_vld_q <= ctl.rd_en;
			done_q   <= imm_done || hit_single || miss || stamp_last;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_nx;
		ev_q  <= rd_q[lra_pkg::REG_BITS-1:0];
		if (accept) begin
			req_q       <= req;
			cnt_q       <= lra_pkg::LEN_W'(req.count);
			rd_q        <= '0;
			run_len_q   <= '0;
			run_start_q <= '0;
		end else if (state_q == lra_pkg::ST_SCAN) begin
			if (ctl.rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (eval && !single_q) begin
				if (fit.all_free) begin
					run_len_q <= run_len_nx;
				end else begin
					run_len_q   <= '0;
					run_start_q <= lra_pkg::LEN_W'(ev_q) + 1'b1;
				end
			end
		end
		if (hit_range) begin
			wr_q   <= run_start_q[lra_pkg::REG_BITS-1:0];
			left_q <= cnt_q;
		end else if (state_q == lra_pkg::ST_STAMP) begin
			wr_q   <= wr_q + 1'b1;
			left_q <= left_q - 1'b1;
		end
	end

	assign busy   = (state_q != lra_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while a request is still in progress");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == lra_pkg::STATUS_FULL)) |->
		((result.write_mask == '0) && (result.reg_id == '0)))
		else $error("no-room result carries a register or mask");

	a_range_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == lra_pkg::STATUS_OK) &&
		(req_q.req_type == lra_pkg::REQ_RANGE) && $past(state_q == lra_pkg::ST_STAMP)) |->
		(result.write_mask == 4'hF))
		else $error("range result without a full write mask");

	a_stamp_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lra_pkg::ST_STAMP) |-> (left_q != '0))
		else $error("range write phase with no registers left");

endmodule

### rtl/lra_store.sv
// ----------------------------------------------------------------------------
// lra_store: component lifetime store
// One row per register holding the last-read index of each component. A row
// valid bit per register makes a cleared row read as all zero.
// ----------------------------------------------------------------------------
module lra_store (
	input  logic                clk,
	input  logic                arst_n,
	input  lra_pkg::store_ctl_t ctl,
	output lra_pkg::row_t       rd_data
);

	lra_pkg::row_t mem [lra_pkg::NUM_REGS];
	logic [lra_pkg::NUM_REGS-1:0] valid_q;
	lra_pkg::row_t rdata_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_q <= valid_q[ctl.rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

### rtl/lra_fit.sv
// ----------------------------------------------------------------------------
// lra_fit: per-register fit check
// Compares the four components of one row against the first-write index and
// picks the lowest free components that the request needs.
// ----------------------------------------------------------------------------
module lra_fit (
	input  lra_pkg::row_t                row,
	input  lra_pkg::index_t              first_def,
	input  logic [lra_pkg::NEED_W-1:0]   need,
	output lra_pkg::fit_t                fit
);

	logic [lra_pkg::COMPS-1:0] free;
	logic [lra_pkg::COMPS-1:0] mask;
	logic [lra_pkg::NEED_W-1:0] got;

	always_comb begin
		got  = '0;
		mask = '0;
		for (int c = 0; c < lra_pkg::COMPS; c++) begin
			free[c] = (row[c] <= first_def);
			if (free[c] && (got < need)) begin
				mask[c] = 1'b1;
				got     = got + 1'b1;
			end
		end
		fit.mask     = mask;
		fit.ok       = (got == need);
		fit.all_free = &free;
	end

endmodule

### tb/liveness_register_allocator_tb.sv
// ----------------------------------------------------------------------------
// liveness_register_allocator_tb: self-checking bench for the allocator
// A driver feeds request beats from a backlog under random sender idling, and
// a monitor checks every result beat against a shadow copy of the
// per-component last-read store that predicts first-fit grants for
// single-register and range requests, clears, bad counts and unknown requests.
// ----------------------------------------------------------------------------
module liveness_register_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lra_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE_CYCLES = 2 * NUM_REGS + 20;

	typedef struct {
		req_t beat;
		bit   drain;
	} backlog_item_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	req_t  req = '0;
	logic  busy;
	logic  done;
	res_t  result;

	backlog_item_t request_backlog[$];
	res_t          expected_grants[$];
	index_t        shadow_last_read[NUM_REGS * COMPS];

	int beats_sent = 0;
	int beats_taken = 0;
	int total_items = 0;
	int err_cnt = 0;
	int stall_cycles = 0;

	liveness_register_allocator dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [COMPS-1:0] free_comps(int reg_n, index_t fw, int need);
		logic [COMPS-1:0] m;
		int got;
		m = '0;
		got = 0;
		for (int c = 0; c < COMPS; c++) begin
			if (got < need && shadow_last_read[reg_n * COMPS + c] <= fw) begin
				m[c] = 1'b1;
				got++;
			end
		end
		return (got == need) ? m : '0;
	endfunction

	task automatic stamp_comps(int reg_n, logic [COMPS-1:0] m, index_t lr);
		for (int c = 0; c < COMPS; c++) begin
			if (m[c]) begin
				shadow_last_read[reg_n * COMPS + c] = lr;
			end
		end
	endtask

	task automatic alloc_predict(input req_t r);
		res_t g;
		logic [COMPS-1:0] m;
		int cnt;
		bit hit;
		bit run_ok;
		g = '0;
		cnt = int'(r.count);
		hit = 1'b0;
		case (req_type_t'(r.req_type))
			REQ_CLEAR: begin
				foreach (shadow_last_read[i]) shadow_last_read[i] = '0;
			end
			REQ_SINGLE: begin
				g.status = STATUS_FULL;
				if (cnt >= 1 && cnt <= COMPS) begin
					for (int reg_n = 0; reg_n < NUM_REGS && !hit; reg_n++) begin
						m = free_comps(reg_n, r.first_def, cnt);
						if (m != '0) begin
							stamp_comps(reg_n, m, r.last_use);
							g.reg_id = 6'(reg_n);
							g.write_mask = m;
							g.status = STATUS_OK;
							hit = 1'b1;
						end
					end
				end
			end
			REQ_RANGE: begin
				g.status = STATUS_FULL;
				if (cnt >= 1 && cnt <= NUM_REGS) begin
					for (int base = 0; base + cnt <= NUM_REGS && !hit; base++) begin
						run_ok = 1'b1;
						for (int k = 0; k < cnt && run_ok; k++) begin
							if (free_comps(base + k, r.first_def, COMPS) == '0) begin
								run_ok = 1'b0;
							end
						end
						if (run_ok) begin
							for (int k = 0; k < cnt; k++) begin
								stamp_comps(base + k, '1, r.last_use);
							end
							g.reg_id = 6'(base);
							g.write_mask = '1;
							g.status = STATUS_OK;
							hit = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		expected_grants.push_back(g);
	endtask

	task automatic queue_req(req_type_t kind, int fw, int lr, int cnt, bit drain = 1'b0);
		backlog_item_t it;
		it.beat.req_type = kind;
		it.beat.first_def = 16'(fw);
		it.beat.last_use = 16'(lr);
		it.beat.count = 7'(cnt);
		it.drain = drain;
		request_backlog.push_back(it);
	endtask

	function automatic int idle_pct();
		if (beats_sent * 3 < total_items) begin
			return 28;
		end else if (beats_sent * 3 < total_items * 2) begin
			return 87;
		end
		return 0;
	endfunction

	// A new beat is offered only once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && beats_taken == beats_sent) begin
			if (request_backlog.size() != 0
					&& !(request_backlog[0].drain && expected_grants.size() != 0)
					&& $urandom_range(0, 99) >= idle_pct()) begin
				req <= request_backlog[0].beat;
				start <= 1'b1;
				void'(request_backlog.pop_front());
				beats_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t exp_g;
		if (arst_n) begin
			if (done) begin
				if (expected_grants.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("%0t: unexpected result beat: reg %0d mask %h status %0d",
							$realtime, result.reg_id, result.write_mask, result.status);
					end
				end else begin
					exp_g = expected_grants.pop_front();
					if (result.reg_id !== exp_g.reg_id
							|| result.write_mask !== exp_g.write_mask
							|| result.status !== exp_g.status) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("%0t: grant mismatch: expected reg %0d mask %h status %0d,",
								" got reg %0d mask %h status %0d",
								$realtime, exp_g.reg_id, exp_g.write_mask, exp_g.status,
								result.reg_id, result.write_mask, result.status);
						end
					end
				end
			end
			if (start && !busy) begin
				alloc_predict(req);
				beats_taken <= beats_taken + 1;
			end
			if (done || (start && !busy)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int pc;
		int pick;
		int lr;
		int cnt;
		foreach (shadow_last_read[i]) shadow_last_read[i] = '0;

		queue_req(REQ_SINGLE, 0, 0, 1);
		queue_req(REQ_SINGLE, 0, 65535, 4);
		queue_req(REQ_SINGLE, 0, 0, 0);
		queue_req(REQ_SINGLE, 0, 0, 5);
		queue_req(REQ_SINGLE, 65535, 65535, 127);
		queue_req(REQ_RANGE, 0, 1, 64);
		queue_req(REQ_RANGE, 0, 1, 0);
		queue_req(REQ_RANGE, 0, 1, 65);
		queue_req(REQ_RANGE, 65535, 65535, 127);
		queue_req(REQ_NOP, 65535, 65535, 127);
		queue_req(REQ_CLEAR, 0, 0, 1, 1'b1);
		queue_req(REQ_RANGE, 0, 65535, 64);
		queue_req(REQ_SINGLE, 65535, 0, 1);
		queue_req(REQ_SINGLE, 65534, 100, 4);
		queue_req(REQ_CLEAR, 0, 0, 1);
		queue_req(REQ_RANGE, 0, 5, 1);
		queue_req(REQ_RANGE, 0, 7, 63);
		queue_req(REQ_SINGLE, 4, 9, 1);
		queue_req(REQ_CLEAR, 0, 0, 1);
		queue_req(REQ_SINGLE, 0, 10, 4);
		queue_req(REQ_SINGLE, 10, 30, 1);
		queue_req(REQ_SINGLE, 10, 12, 1);
		queue_req(REQ_SINGLE, 10, 30, 1);
		queue_req(REQ_SINGLE, 12, 40, 2);
		queue_req(REQ_CLEAR, 0, 0, 1);

		// Well-formed requests follow a rising instruction index with short
		// lifetimes, so the file fills and drains; the rest is noise.
		pc = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			lr = ($urandom_range(0, 39) == 0) ? 65535 : pc + $urandom_range(0, 120);
			if (lr > 65535) begin
				lr = 65535;
			end
			if (pc > 60000) begin
				queue_req(REQ_CLEAR, 0, 0, 1);
				pc = 0;
			end else if (pick < 10) begin
				queue_req(req_type_t'($urandom_range(0, 3)), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 127), i % 300 == 0);
			end else if (pick < 13) begin
				queue_req(REQ_CLEAR, pc, lr, $urandom_range(1, 127));
			end else if (pick < 63) begin
				queue_req(REQ_SINGLE, pc, lr, $urandom_range(1, 4));
			end else begin
				cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
				queue_req(REQ_RANGE, pc, lr, cnt);
			end
			pc += $urandom_range(0, 6);
		end
		total_items = request_backlog.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || beats_taken != beats_sent) @(negedge clk);
		while (expected_grants.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		err_cnt += expected_grants.size();
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
